### src/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg: free list allocator shared definitions
// Slot geometry, link encoding, action and status codes, and the
// controller-to-datapath command and status bundles.
// ----------------------------------------------------------------------------
package fla_pkg;

   localparam int SLOTS   = 256;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int LINK_W  = IDX_W + 1;
   localparam int COUNT_W = IDX_W + 1;

   // Null link is the value SLOTS, so its top bit marks it.
   localparam logic [LINK_W-1:0]  NULL_LINK = LINK_W'(SLOTS);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(SLOTS);

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;

   typedef struct packed {
      logic push;   // free: link slot in at head, load result
      logic fail;   // allocate on empty list: load failure result
      logic pop;    // allocate: follow link of head, load result
   } fla_cmd_type;

   typedef struct packed {
      logic head_null;
   } fla_stat_type;

endpackage

### src/free_list_slot_allocator.sv
// A free or a failed allocate shows its result in the cycle after accept;
// a successful allocate first waits in S_LOOK for the registered read of
// the link RAM. Throughput: one free or failed allocate per cycle while the
// result is not stalled; S_LOOK holds off new requests during that read.
// Reset (synchronous, active high) and any slot_count write rebuild the list
// at once: per-slot valid bits clear, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// free_list_slot_allocator: linked free list of fixed-size slots
// Allocate pops the head slot, free pushes a slot onto the head.
// ----------------------------------------------------------------------------
module free_list_slot_allocator import fla_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [COUNT_W-1:0]     csr_wdata,   // slot_count
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] slot_index
   input  logic                   req_tuser,   // [0] action
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [7:0] granted_slot, [8] pool_empty
   output logic [1:0]             rsp_tuser    // [1:0] status
);

   fla_cmd_type      cmd;
   fla_stat_type     stat;
   logic [IDX_W-1:0] granted_slot;
   logic             pool_empty;

   fla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fla_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .slot_index   (req_tdata[IDX_W-1:0]),
      .cmd          (cmd),
      .stat         (stat),
      .granted_slot (granted_slot),
      .status       (rsp_tuser),
      .pool_empty   (pool_empty)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-IDX_W-1){1'b0}}, pool_empty, granted_slot};

endmodule

### src/fla_ram.sv
// ----------------------------------------------------------------------------
// fla_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module fla_ram #(
   parameter int DATA_W = 9,
   parameter int DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/fla_datapath.sv
// ----------------------------------------------------------------------------
// fla_datapath: free list head, link store and result register
// Links never written since the last rebuild read as the ascending
// default, tracked by one valid bit per slot.
// ----------------------------------------------------------------------------
module fla_datapath import fla_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [COUNT_W-1:0]  csr_wdata,
   input  logic [IDX_W-1:0]    slot_index,
   input  fla_cmd_type         cmd,
   output fla_stat_type        stat,
   output logic [IDX_W-1:0]    granted_slot,
   output logic [1:0]          status,
   output logic                pool_empty
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [IDX_W-1:0]   granted_ff, granted_in;
   logic [1:0]         status_ff, status_in;
   logic               empty_ff, empty_in;

   logic [COUNT_W-1:0] eff_count;
   logic               in_range;
   logic               ram_we;
   logic [LINK_W-1:0]  ram_q;
   logic [LINK_W-1:0]  head_inc;
   logic [LINK_W-1:0]  link_dflt;
   logic [LINK_W-1:0]  link;

   assign eff_count = (csr_wdata > MAX_COUNT) ? MAX_COUNT : csr_wdata;
   assign in_range  = {1'b0, slot_index} < count_ff;
   assign ram_we    = cmd.push && in_range;

   fla_ram #(
      .DATA_W (LINK_W),
      .DEPTH  (SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_index),
      .wr_data (head_ff),
      .rd_addr (head_ff[IDX_W-1:0]),
      .rd_data (ram_q)
   );

   // Default link after a rebuild: next slot up, null at the end of the pool.
   assign head_inc  = {1'b0, head_ff[IDX_W-1:0]} + LINK_W'(1);
   assign link_dflt = (head_inc < count_ff) ? head_inc : NULL_LINK;
   assign link      = valid_ff[head_ff[IDX_W-1:0]] ? ram_q : link_dflt;

   always_comb begin
      count_in   = count_ff;
      head_in    = head_ff;
      valid_in   = valid_ff;
      granted_in = granted_ff;
      status_in  = status_ff;
      empty_in   = empty_ff;
      if (csr_we) begin
         count_in = eff_count;
         head_in  = (eff_count != '0) ? '0 : NULL_LINK;
         valid_in = '0;
      end else if (cmd.push) begin
         granted_in = '0;
         if (in_range) begin
            head_in              = {1'b0, slot_index};
            valid_in[slot_index] = 1'b1;
            status_in            = ST_OK;
            empty_in             = 1'b0;
         end else begin
            status_in = ST_RANGE;
            empty_in  = head_ff[IDX_W];
         end
      end else if (cmd.fail) begin
         granted_in = '0;
         status_in  = ST_EMPTY;
         empty_in   = 1'b1;
      end else if (cmd.pop) begin
         head_in    = link;
         granted_in = head_ff[IDX_W-1:0];
         status_in  = ST_OK;
         empty_in   = link[IDX_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= MAX_COUNT;
         head_ff  <= '0;
         valid_ff <= '0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
         valid_ff <= valid_in;
      end
      granted_ff <= granted_in;
      status_ff  <= status_in;
      empty_ff   <= empty_in;
   end

   assign stat.head_null = head_ff[IDX_W];
   assign granted_slot   = granted_ff;
   assign status         = status_ff;
   assign pool_empty     = empty_ff;

endmodule

### src/fla_ctrl.sv
// ----------------------------------------------------------------------------
// fla_ctrl: request sequencer
// Accepts one item at a time, waits in S_LOOK for the link read on a
// successful allocate, and owns the result valid flag.
// ----------------------------------------------------------------------------
module fla_ctrl import fla_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_action,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  fla_stat_type  stat,
   output fla_cmd_type   cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LOOK = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic load;

   assign req_tready = !reset && (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action == ACT_FREE) begin
                  cmd.push = 1'b1;
               end else if (stat.head_null) begin
                  cmd.fail = 1'b1;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            cmd.pop  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign load         = cmd.push || cmd.fail || cmd.pop;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### src/fla_checker.sv
// ----------------------------------------------------------------------------
// fla_checker: port-level checks for the free list allocator
// Watches the result channel for consistent status, slot and empty flags.
// ----------------------------------------------------------------------------
module fla_checker import fla_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]             rsp_tuser
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed or dropped");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK || rsp_tuser == ST_EMPTY || rsp_tuser == ST_RANGE))
      else $error("undefined status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[IDX_W-1:0] == '0)
      else $error("slot reported on a failed item");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_EMPTY |-> rsp_tdata[IDX_W])
      else $error("allocate failure without empty pool");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("item accepted while result stalled");

endmodule

bind free_list_slot_allocator fla_checker u_fla_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### sim/free_list_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// free_list_slot_allocator_tb: self-checking bench for the slot allocator
// Walks a table of directed requests, then runs random alloc/free traffic
// over several pool sizes. A local model of the free list predicts every response
// the table does not give; responses are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module free_list_slot_allocator_tb;
   import fla_pkg::*;

   localparam int MAX_REPORTS = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEMS_PER_PHASE = 45;
   localparam int NUM_PHASES = 9;

   typedef struct packed {
      logic [IDX_W-1:0] slot;
      logic [1:0]       status;
      logic             empty;
   } grant_type;

   typedef struct packed {
      bit                 is_cfg;
      logic [COUNT_W-1:0] count;
      logic               act;
      logic [IDX_W-1:0]   idx;
      bit                 typed;
      grant_type          want;
   } dir_row_type;

   localparam int DIR_ROWS = 31;

   // cyclic list after the double free of slot 2; extremes of the count
   dir_row_type dir_rows [0:DIR_ROWS-1] = '{
      '{1'b0, 9'd0,   ACT_ALLOC, 8'd0,   1'b1, '{8'd0,   ST_OK,    1'b0}},
      '{1'b0, 9'd0,   ACT_ALLOC, 8'd0,   1'b1, '{8'd1,   ST_OK,    1'b0}},
      '{1'b0, 9'd0,   ACT_FREE,  8'd0,   1'b1, '{8'd0,   ST_OK,    1'b0}},
      '{1'b0, 9'd0,   ACT_FREE,  8'd255, 1'b1, '{8'd0,   ST_OK,    1'b0}},
      '{1'b0, 9'd0,   ACT_ALLOC, 8'd0,   1'b1, '{8'd255, ST_OK,    1'b0}},
      '{1'b0, 9'd0,   ACT_ALLOC, 8'd0,   1'b1, '{8'd0,   ST_OK,    1'b0}},
      '{1'b0, 9'd0,   ACT_FREE,  8'd2,   1'b0, '0},
      '{1'b0, 9'd0,   ACT_ALLOC, 8'd0,   1'b0, '0},
      '{1'b0, 9'd0,   ACT_ALLOC, 8'd0,   1'b0, '0},
      '{1'b1, 9'd1,   ACT_ALLOC, 8'd0,   1'b0, '0},
      '{1'b0, 9'd0,   ACT_ALLOC, 8'd0,   1'b1, '{8'd0,   ST_OK,    1'b1}},
      '{1'b0, 9'd0,   ACT_ALLOC, 8'd0,   1'b1, '{8'd0,   ST_EMPTY, 1'b1}},
      '{1'b0, 9'd0,   ACT_FREE,  8'd1,   1'b1, '{8'd0,   ST_RANGE, 1'b1}},
      '{1'b0, 9'd0,   ACT_FREE,  8'd0,   1'b1, '{8'd0,   ST_OK,    1'b0}},
      '{1'b1, 9'd0,   ACT_ALLOC, 8'd0,   1'b0, '0},
      '{1'b0, 9'd0,   ACT_ALLOC, 8'd0,   1'b1, '{8'd0,   ST_EMPTY, 1'b1}},
      '{1'b0, 9'd0,   ACT_FREE,  8'd0,   1'b1, '{8'd0,   ST_RANGE, 1'b1}},
      '{1'b0, 9'd0,   ACT_FREE,  8'd255, 1'b1, '{8'd0,   ST_RANGE, 1'b1}},
      '{1'b1, 9'd300, ACT_ALLOC, 8'd0,   1'b0, '0},
      '{1'b0, 9'd0,   ACT_FREE,  8'd255, 1'b1, '{8'd0,   ST_OK,    1'b0}},
      '{1'b0, 9'd0,   ACT_ALLOC, 8'd0,   1'b1, '{8'd255, ST_OK,    1'b0}},
      '{1'b1, 9'd2,   ACT_ALLOC, 8'd0,   1'b0, '0},
      '{1'b0, 9'd0,   ACT_ALLOC, 8'd0,   1'b1, '{8'd0,   ST_OK,    1'b0}},
      '{1'b0, 9'd0,   ACT_ALLOC, 8'd0,   1'b1, '{8'd1,   ST_OK,    1'b1}},
      '{1'b0, 9'd0,   ACT_ALLOC, 8'd0,   1'b1, '{8'd0,   ST_EMPTY, 1'b1}},
      '{1'b0, 9'd0,   ACT_FREE,  8'd1,   1'b1, '{8'd0,   ST_OK,    1'b0}},
      '{1'b0, 9'd0,   ACT_FREE,  8'd2,   1'b1, '{8'd0,   ST_RANGE, 1'b0}},
      '{1'b1, 9'd511, ACT_ALLOC, 8'd0,   1'b0, '0},
      '{1'b0, 9'd0,   ACT_FREE,  8'd170, 1'b0, '0},
      '{1'b0, 9'd0,   ACT_FREE,  8'd85,  1'b0, '0},
      '{1'b0, 9'd0,   ACT_ALLOC, 8'd0,   1'b0, '0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [COUNT_W-1:0]     csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;

   // local copy of the free list
   logic [LINK_W-1:0]  pool_head;
   logic [LINK_W-1:0]  pool_link [SLOTS];
   logic [COUNT_W-1:0] pool_count;

   grant_type        pending_grants [$];
   logic [IDX_W-1:0] held_slots [$];

   int mismatches = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int stall_left = 0;
   int n_granted = 0;
   int n_empty = 0;
   int n_range = 0;
   int n_released = 0;

   free_list_slot_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_grants.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic void rebuild_pool(logic [COUNT_W-1:0] written);
      pool_count = (written > MAX_COUNT) ? MAX_COUNT : written;
      for (int i = 0; i < SLOTS; i++)
         pool_link[i] = (i + 1 < pool_count) ? LINK_W'(i + 1) : NULL_LINK;
      pool_head = (pool_count != 0) ? '0 : NULL_LINK;
      held_slots.delete();
   endfunction

   // pop or push the head; returns the response the allocator should give
   function automatic grant_type grant_or_release(logic act, logic [IDX_W-1:0] idx);
      grant_type g;
      g = '{slot: '0, status: ST_OK, empty: 1'b0};
      if (act == ACT_ALLOC) begin
         if (pool_head >= NULL_LINK) begin
            g.status = ST_EMPTY;
         end else begin
            g.slot = pool_head[IDX_W-1:0];
            pool_head = pool_link[pool_head[IDX_W-1:0]];
         end
      end else begin
         if ({1'b0, idx} >= pool_count) begin
            g.status = ST_RANGE;
         end else begin
            pool_link[idx] = pool_head;
            pool_head = {1'b0, idx};
         end
      end
      g.empty = (pool_head >= NULL_LINK);
      return g;
   endfunction

   // receiver: always ready, coin-flip, or occasional long stalls
   always @(posedge clock) begin
      case ((cycle_count / 128) % 3)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: begin
            if (stall_left > 0) begin
               stall_left <= stall_left - 1;
               rsp_tready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
               stall_left <= $urandom_range(3, 12);
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: slot %0d status %0d empty %0d",
                        rsp_tdata[7:0], rsp_tuser, rsp_tdata[8]);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_tdata[7:0] !== want.slot || rsp_tuser !== want.status ||
                rsp_tdata[8] !== want.empty) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("cycle %0d: expected slot %0d status %0d empty %0d, got %0d %0d %0d",
                           cycle_count, want.slot, want.status, want.empty,
                           rsp_tdata[7:0], rsp_tuser, rsp_tdata[8]);
            end
         end
      end
   end

   // insert a random gap at the end of each burst
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic issue(logic act, logic [IDX_W-1:0] idx, bit typed, grant_type want);
      grant_type g;
      pace();
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= idx;
      do @(posedge clock); while (!req_tready);
      g = grant_or_release(act, idx);
      if (g.status == ST_EMPTY) n_empty++;
      else if (g.status == ST_RANGE) n_range++;
      else if (act == ACT_ALLOC) begin
         n_granted++;
         held_slots.push_back(g.slot);
      end else n_released++;
      pending_grants.push_back(typed ? want : g);
   endtask

   // drain, let the last allocate settle, then write the pool size
   task automatic write_count(logic [COUNT_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      rebuild_pool(value);
   endtask

   initial begin
      logic [COUNT_W-1:0] phase_counts [NUM_PHASES];
      logic [IDX_W-1:0]   idx;
      int roll;
      int k;
      phase_counts = '{9'd256, 9'd3, 9'd1, 9'd0, 9'd40, 9'd511, 9'd2, 9'd300, 9'd0};
      phase_counts[NUM_PHASES-1] = COUNT_W'($urandom_range(1, 256));
      rebuild_pool(MAX_COUNT);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         if (dir_rows[r].is_cfg)
            write_count(dir_rows[r].count);
         else
            issue(dir_rows[r].act, dir_rows[r].idx, dir_rows[r].typed, dir_rows[r].want);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_count(phase_counts[p]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            idx = IDX_W'($urandom_range(0, 255));
            if (roll < 50) begin
               issue(ACT_ALLOC, idx, 1'b0, '0);
            end else if (roll < 80 && held_slots.size() != 0) begin
               // return a slot that is actually out
               k = $urandom_range(0, held_slots.size() - 1);
               idx = held_slots[k];
               held_slots.delete(k);
               issue(ACT_FREE, idx, 1'b0, '0);
            end else if (roll < 88 || pool_count == 0) begin
               issue(ACT_FREE, idx, 1'b0, '0);
            end else if (roll < 94 || pool_count == MAX_COUNT) begin
               // may hit a slot already on the list
               idx = IDX_W'($urandom_range(0, pool_count - 1));
               issue(ACT_FREE, idx, 1'b0, '0);
            end else begin
               idx = IDX_W'($urandom_range(pool_count, 255));
               issue(ACT_FREE, idx, 1'b0, '0);
            end
         end
      end

      req_tvalid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("covered %0d grants, %0d frees, %0d empty-pool and %0d out-of-range requests",
               n_granted, n_released, n_empty, n_range);
      $display("over %0d pool sizes from empty to saturated; %0d mismatches",
               NUM_PHASES + 5, mismatches);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
